FILE: rtl/lsn_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor normalizer package
// Shared widths, constants, command codes and the item and result structures.
// ----------------------------------------------------------------------------
package lsn_pkg;

  // Field widths of the sample and result channels.
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 4;
  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 10;
  localparam int COUNT_W  = 16;

  // Scaling constants.
  localparam int SAMPLE_MAX = 4095;
  localparam int FULL_SCALE = 1000;
  localparam int HALF_SCALE = FULL_SCALE / 2;

  // Dividend of the normalizing division: sample difference times full scale.
  localparam int NUM_W  = SAMPLE_W + LEVEL_W;
  localparam int STEP_W = $clog2(LEVEL_W);

  // Defaults for the top-level parameters.
  localparam int SENSOR_COUNT_DEF = 13;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_LEVEL = 1'b1;

  localparam logic [SAMPLE_W-1:0] MIN_SPAN_RST  = SAMPLE_W'(100);
  localparam logic [LEVEL_W-1:0]  THRESHOLD_RST = LEVEL_W'(600);

  // Commands carried by a sample beat.
  typedef enum logic [CMD_W-1:0] {
    CMD_CALIBRATE  = 2'd0,
    CMD_MEASURE    = 2'd1,
    CMD_RESET_CAL  = 2'd2,
    CMD_RESET_MARK = 2'd3
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  // Classified item as it travels through the queue.
  typedef struct packed {
    cmd_t                cmd;
    logic [IDX_W-1:0]    idx;
    logic                in_range;
    logic                is_left;
    logic                is_right;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [LEVEL_W-1:0] normalized;
    logic               on_marker;
    logic               marker_edge;
    logic [COUNT_W-1:0] left_markers;
    logic [COUNT_W-1:0] right_markers;
  } result_t;

endpackage

FILE: rtl/lsn_if.sv
// ----------------------------------------------------------------------------
// Line sensor normalizer channels
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
interface lsn_in_if;
  import lsn_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [IDX_W-1:0]    sensor_index;
  logic [SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output command, output sensor_index, output raw_sample,
                  input ready);
  modport sink   (input valid, input command, input sensor_index, input raw_sample,
                  output ready);
endinterface

interface lsn_out_if;
  import lsn_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] normalized;
  logic               on_marker;
  logic               marker_edge;
  logic [COUNT_W-1:0] left_markers;
  logic [COUNT_W-1:0] right_markers;

  modport source (output valid, output normalized, output on_marker, output marker_edge,
                  output left_markers, output right_markers, input ready);
  modport sink   (input valid, input normalized, input on_marker, input marker_edge,
                  input left_markers, input right_markers, output ready);
endinterface

FILE: rtl/line_sensor_calibrate_normalize_marker_unit.sv
// ----------------------------------------------------------------------------
// Line sensor calibrate, normalize and marker unit
// Min/max calibrated normalization of line sensor samples with side marker
// edge counting.
// ----------------------------------------------------------------------------
// Each accepted sample beat is queued, then taken by the back-end sequencer through
// its execute state, the divide state for a measure that divides, and the emit state.
// The sequencer works on one item at a time; its bit-serial divider produces one
// quotient bit per cycle, and the queue takes new beats while it has room.
// Reset: empties the queue, restores the calibration table (max 0, min the
// largest sample), clears the marker counters and loads the register defaults.
module line_sensor_calibrate_normalize_marker_unit #(
  parameter int SENSOR_COUNT = lsn_pkg::SENSOR_COUNT_DEF,
  parameter int QUEUE_DEPTH  = lsn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lsn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsn_pkg::CFG_DATA_W-1:0] cfg_data,
  lsn_in_if.sink                        sample_ch,
  lsn_out_if.source                     result_ch
);
  import lsn_pkg::*;

  item_t push_item;
  item_t pop_item;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  // Front end: accept and classify.
  lsn_front #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_front (
    .sample_ch (sample_ch),
    .q_full    (full),
    .q_push    (push),
    .q_item    (push_item)
  );

  // Queue between the two ends.
  lsn_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full),
    .empty     (empty)
  );

  // Back end: execute and report.
  lsn_back #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (empty),
    .q_item    (pop_item),
    .q_pop     (pop),
    .result_ch (result_ch)
  );

endmodule

FILE: rtl/lsn_front.sv
// ----------------------------------------------------------------------------
// Line sensor normalizer front end
// Accepts sample beats, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module lsn_front #(
  parameter int SENSOR_COUNT = lsn_pkg::SENSOR_COUNT_DEF
) (
  lsn_in_if.sink        sample_ch,
  input  logic          q_full,
  output logic          q_push,
  output lsn_pkg::item_t q_item
);
  import lsn_pkg::*;

  logic in_range;

  // A beat is taken whenever the queue has room.
  assign sample_ch.ready = !q_full;
  assign q_push          = sample_ch.valid && !q_full;

  // Classify the index: range check and the two side sensors.
  assign in_range = sample_ch.sensor_index < SENSOR_COUNT;

  always_comb begin
    q_item.cmd      = cmd_t'(sample_ch.command);
    q_item.idx      = sample_ch.sensor_index;
    q_item.in_range = in_range;
    q_item.is_left  = in_range && (sample_ch.sensor_index == 0);
    q_item.is_right = in_range && (sample_ch.sensor_index == SENSOR_COUNT - 1);
    // Saturate the reading to the converter full scale.
    if (sample_ch.raw_sample > SAMPLE_MAX) begin
      q_item.sample = SAMPLE_W'(SAMPLE_MAX);
    end else begin
      q_item.sample = sample_ch.raw_sample;
    end
  end

endmodule

FILE: rtl/lsn_fifo.sv
// ----------------------------------------------------------------------------
// Line sensor normalizer item queue
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module lsn_fifo #(
  parameter int DEPTH = lsn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lsn_pkg::item_t push_item,
  input  logic           pop,
  output lsn_pkg::item_t pop_item,
  output logic           full,
  output logic           empty
);
  import lsn_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/lsn_back.sv
// ----------------------------------------------------------------------------
// Line sensor normalizer back end
// Runs the commands: calibration table, bit-serial normalizing divider,
// side marker counters and the result register.
// ----------------------------------------------------------------------------
module lsn_back #(
  parameter int SENSOR_COUNT = lsn_pkg::SENSOR_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lsn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          q_empty,
  input  lsn_pkg::item_t                q_item,
  output logic                          q_pop,
  lsn_out_if.source                     result_ch
);
  import lsn_pkg::*;

  localparam int TAB_AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  back_state_t state, state_next;

  // Configuration registers.
  logic [SAMPLE_W-1:0] min_span;
  logic [LEVEL_W-1:0]  mark_level;

  // Calibration table and marker state.
  logic [SAMPLE_W-1:0] cal_max [SENSOR_COUNT];
  logic [SAMPLE_W-1:0] cal_min [SENSOR_COUNT];
  logic                left_prev_on;
  logic                right_prev_on;
  logic [COUNT_W-1:0]  left_count;
  logic [COUNT_W-1:0]  right_count;

  // Work registers of the item in flight.
  item_t               item;
  logic [LEVEL_W-1:0]  level;
  logic [NUM_W-1:0]    rem;
  logic [NUM_W-1:0]    dsh;
  logic [STEP_W-1:0]   step;

  // Result register.
  logic                res_valid;
  result_t             res;

  logic [TAB_AW-1:0]   addr;
  logic [SAMPLE_W-1:0] hi;
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] span;
  logic                narrow;
  logic                is_measure;
  logic                start_div;
  logic [LEVEL_W-1:0]  exec_level;
  logic [NUM_W-1:0]    numer;
  logic                ge;
  logic                slot_free;
  logic                commit;
  logic                on;
  logic                edge_seen;
  logic [COUNT_W-1:0]  left_next;
  logic [COUNT_W-1:0]  right_next;

  // Table read for the item in flight.
  assign addr = TAB_AW'(item.idx);
  assign hi   = item.in_range ? cal_max[addr] : '0;
  assign lo   = item.in_range ? cal_min[addr] : '0;
  assign span = hi - lo;

  // Decide the level, or start the divider when the sample lies inside the span.
  always_comb begin
    is_measure = (item.cmd == CMD_MEASURE);
    narrow     = (hi <= lo) || (span < min_span);
    start_div  = 1'b0;
    exec_level = '0;
    if (is_measure && item.in_range) begin
      if (narrow) begin
        exec_level = LEVEL_W'(HALF_SCALE);
      end else if (item.sample <= lo) begin
        exec_level = '0;
      end else if (item.sample >= hi) begin
        exec_level = LEVEL_W'(FULL_SCALE);
      end else begin
        start_div = 1'b1;
      end
    end
  end

  assign numer = NUM_W'(item.sample - lo) * NUM_W'(FULL_SCALE);
  assign ge    = (rem >= dsh);

  // Marker logic and counter values reported with the result.
  always_comb begin
    on         = is_measure && (item.is_left || item.is_right) && (level > mark_level);
    edge_seen  = 1'b0;
    left_next  = left_count;
    right_next = right_count;
    if (item.cmd == CMD_RESET_MARK) begin
      left_next  = '0;
      right_next = '0;
    end else if (item.is_left) begin
      edge_seen = on && !left_prev_on;
      if (edge_seen) begin
        left_next = left_count + 1'b1;
      end
    end else if (item.is_right) begin
      edge_seen = on && !right_prev_on;
      if (edge_seen) begin
        right_next = right_count + 1'b1;
      end
    end
  end

  assign slot_free = !res_valid || result_ch.ready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and strobes.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = start_div ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (step == STEP_W'(LEVEL_W - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Item capture and bit-serial division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
    end
    if (state == ST_EXEC) begin
      level <= exec_level;
      rem   <= numer;
      dsh   <= NUM_W'(span) << (LEVEL_W - 1);
      step  <= '0;
    end else if (state == ST_DIV) begin
      level <= {level[LEVEL_W-2:0], ge};
      rem   <= ge ? rem - dsh : rem;
      dsh   <= dsh >> 1;
      step  <= step + 1'b1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_span   <= MIN_SPAN_RST;
      mark_level <= THRESHOLD_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIN_SPAN) begin
        min_span <= cfg_data[SAMPLE_W-1:0];
      end else if (cfg_index == CFG_MARKER_LEVEL) begin
        mark_level <= cfg_data[LEVEL_W-1:0];
      end
    end
  end

  // Calibration table: widen on calibrate, restore on reset calibration.
  always_ff @(posedge clk) begin
    if (rst || (commit && item.cmd == CMD_RESET_CAL)) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        cal_max[i] <= '0;
        cal_min[i] <= SAMPLE_W'(SAMPLE_MAX);
      end
    end else if (commit && item.cmd == CMD_CALIBRATE && item.in_range) begin
      if (item.sample > hi) begin
        cal_max[addr] <= item.sample;
      end
      if (item.sample < lo) begin
        cal_min[addr] <= item.sample;
      end
    end
  end

  // Marker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_prev_on  <= 1'b0;
      right_prev_on <= 1'b0;
      left_count    <= '0;
      right_count   <= '0;
    end else if (commit) begin
      left_count  <= left_next;
      right_count <= right_next;
      if (item.cmd == CMD_RESET_MARK) begin
        left_prev_on  <= 1'b0;
        right_prev_on <= 1'b0;
      end else if (is_measure && item.is_left) begin
        left_prev_on <= on;
      end else if (is_measure && item.is_right) begin
        right_prev_on <= on;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (result_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.normalized    <= level;
      res.on_marker     <= on;
      res.marker_edge   <= edge_seen;
      res.left_markers  <= left_next;
      res.right_markers <= right_next;
    end
  end

  assign result_ch.valid         = res_valid;
  assign result_ch.normalized    = res.normalized;
  assign result_ch.on_marker     = res.on_marker;
  assign result_ch.marker_edge   = res.marker_edge;
  assign result_ch.left_markers  = res.left_markers;
  assign result_ch.right_markers = res.right_markers;

  // The partial remainder stays below twice the shifted divisor.
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, rem} < {dsh, 1'b0}))
    else $error("divider remainder out of bound");

  // A new result beat appears only from the emit state.
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_EMIT))
    else $error("result loaded outside emit");

  // Normalized levels never exceed full scale.
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.normalized <= LEVEL_W'(FULL_SCALE)))
    else $error("normalized level above full scale");

  // A counted edge is always reported with the marker seen.
  a_edge_on: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.marker_edge) |-> res.on_marker)
    else $error("marker edge without marker");

endmodule

FILE: tb/line_sensor_calibrate_normalize_marker_unit_test.sv
// ----------------------------------------------------------------------------
// Line sensor normalizer testbench
// Drives sample beats into the calibrate, normalize and marker unit and checks
// every result beat against a cycle-free predictor of the calibration table,
// the normalizing division and the side marker counters. A short table of
// directed items runs first, then phases of calibration bursts and random
// traffic under several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module line_sensor_calibrate_normalize_marker_unit_test;
  import lsn_pkg::*;

  localparam int SENSOR_N   = SENSOR_COUNT_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 20;
  localparam int PHASE_RAND = 66;

  // One row of the directed stimulus table.
  typedef struct {
    cmd_t                cmd;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] sample;
    bit                  typed;
    result_t             want;
  } step_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lsn_in_if  sample_ch ();
  lsn_out_if result_ch ();

  line_sensor_calibrate_normalize_marker_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sample_ch(sample_ch),
    .result_ch(result_ch)
  );

  // Predictor copy of the block state and registers.
  logic [SAMPLE_W-1:0] cal_hi [SENSOR_N];
  logic [SAMPLE_W-1:0] cal_lo [SENSOR_N];
  logic                left_was_on;
  logic                right_was_on;
  logic [COUNT_W-1:0]  left_edges;
  logic [COUNT_W-1:0]  right_edges;
  logic [SAMPLE_W-1:0] span_floor;
  logic [LEVEL_W-1:0]  marker_level;

  result_t   pending_results [$];
  step_row_t directed_rows [$];

  int  errors;
  int  beats_in;
  int  beats_out;
  int  settings_used;
  int  idle_cycles;
  bit  steady;

  // Clock: 20 time units.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Work out the result beat of one item and advance the predicted state.
  function automatic result_t normalize_and_count(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                                                  input logic [SAMPLE_W-1:0] s);
    result_t r;
    int      level;
    int      hi;
    int      lo;
    int      sv;
    bit      on;
    bit      hit;
    bit      in_range;
    level    = 0;
    on       = 1'b0;
    hit      = 1'b0;
    in_range = idx < SENSOR_N;
    sv       = s;
    case (cmd)
      CMD_CALIBRATE: begin
        if (in_range) begin
          if (s > cal_hi[idx]) cal_hi[idx] = s;
          if (s < cal_lo[idx]) cal_lo[idx] = s;
        end
      end
      CMD_MEASURE: begin
        if (in_range) begin
          hi = cal_hi[idx];
          lo = cal_lo[idx];
          // Uncalibrated or too narrow a span reads as midscale.
          if (hi <= lo || (hi - lo) < int'(span_floor)) begin
            level = HALF_SCALE;
          end else if (sv <= lo) begin
            level = 0;
          end else begin
            level = ((sv - lo) * FULL_SCALE) / (hi - lo);
            if (level > FULL_SCALE) level = FULL_SCALE;
          end
          if (idx == 0) begin
            on  = level > int'(marker_level);
            hit = on && !left_was_on;
            if (hit) left_edges = left_edges + 1'b1;
            left_was_on = on;
          end else if (idx == SENSOR_N - 1) begin
            on  = level > int'(marker_level);
            hit = on && !right_was_on;
            if (hit) right_edges = right_edges + 1'b1;
            right_was_on = on;
          end
        end
      end
      CMD_RESET_CAL: begin
        for (int i = 0; i < SENSOR_N; i++) begin
          cal_hi[i] = '0;
          cal_lo[i] = SAMPLE_W'(SAMPLE_MAX);
        end
      end
      default: begin
        left_was_on  = 1'b0;
        right_was_on = 1'b0;
        left_edges   = '0;
        right_edges  = '0;
      end
    endcase
    r.normalized    = LEVEL_W'(level);
    r.on_marker     = on;
    r.marker_edge   = hit;
    r.left_markers  = left_edges;
    r.right_markers = right_edges;
    return r;
  endfunction

  // Offer one sample beat after a random gap and log its expected result.
  task automatic send_item(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] s, input bit typed, input result_t want);
    int      gap;
    result_t r;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.command      <= cmd;
    sample_ch.sensor_index <= idx;
    sample_ch.raw_sample   <= s;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    r = normalize_and_count(cmd, idx, s);
    pending_results.push_back(typed ? want : r);
    beats_in++;
    if (beats_in % 32 == 0) steady = ($urandom_range(0, 3) == 0);
    @(negedge clk);
  endtask

  // Wait until the block is idle, then load both registers.
  task automatic set_registers(input logic [SAMPLE_W-1:0] span, input logic [LEVEL_W-1:0] thr);
    sample_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_SPAN;
    cfg_data  <= CFG_DATA_W'(span);
    @(negedge clk);
    cfg_index <= CFG_MARKER_LEVEL;
    cfg_data  <= CFG_DATA_W'(thr);
    @(negedge clk);
    cfg_we       <= 1'b0;
    span_floor   = span;
    marker_level = thr;
    settings_used++;
  endtask

  // Calibration burst over every sensor, then mostly well-formed random traffic.
  task automatic run_phase(input int n_random);
    int                  pick;
    cmd_t                cmd;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] s;
    for (int i = 0; i < SENSOR_N; i++) begin
      s = ($urandom_range(0, 3) == 0) ? '0 : SAMPLE_W'($urandom_range(0, 1200));
      send_item(CMD_CALIBRATE, IDX_W'(i), s, 1'b0, '0);
      s = ($urandom_range(0, 3) == 0) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'($urandom_range(2500, 4095));
      send_item(CMD_CALIBRATE, IDX_W'(i), s, 1'b0, '0);
    end
    for (int n = 0; n < n_random; n++) begin
      pick = $urandom_range(0, 99);
      s    = SAMPLE_W'($urandom);
      if (pick < 40) begin
        cmd = CMD_MEASURE;
        idx = $urandom_range(0, 1) ? '0 : IDX_W'(SENSOR_N - 1);
      end else if (pick < 58) begin
        cmd = CMD_CALIBRATE;
        idx = IDX_W'($urandom_range(0, SENSOR_N - 1));
      end else if (pick < 78) begin
        cmd = CMD_MEASURE;
        idx = IDX_W'($urandom);
      end else if (pick < 81) begin
        cmd = CMD_RESET_CAL;
        idx = IDX_W'($urandom);
      end else if (pick < 85) begin
        cmd = CMD_RESET_MARK;
        idx = IDX_W'($urandom);
      end else begin
        cmd = cmd_t'($urandom_range(0, 3));
        idx = IDX_W'($urandom);
      end
      send_item(cmd, idx, s, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, then compare each beat with the oldest expectation.
  initial begin
    int      stall;
    result_t want;
    result_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      beats_out++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result beat %0d arrived with nothing expected", beats_out));
      end else begin
        want = pending_results.pop_front();
        if (result_ch.normalized !== want.normalized)
          flag_error($sformatf("beat %0d normalized got %0d expected %0d", beats_out,
                               result_ch.normalized, want.normalized));
        if (result_ch.on_marker !== want.on_marker)
          flag_error($sformatf("beat %0d on_marker got %0b expected %0b", beats_out,
                               result_ch.on_marker, want.on_marker));
        if (result_ch.marker_edge !== want.marker_edge)
          flag_error($sformatf("beat %0d marker_edge got %0b expected %0b", beats_out,
                               result_ch.marker_edge, want.marker_edge));
        if (result_ch.left_markers !== want.left_markers)
          flag_error($sformatf("beat %0d left_markers got %0d expected %0d", beats_out,
                               result_ch.left_markers, want.left_markers));
        if (result_ch.right_markers !== want.right_markers)
          flag_error($sformatf("beat %0d right_markers got %0d expected %0d", beats_out,
                               result_ch.right_markers, want.right_markers));
      end
      @(negedge clk);
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Main sequence: reset, directed table, register phases, drain.
  initial begin
    result_t mid;
    result_t zero;
    beats_in               = 0;
    settings_used          = 0;
    steady                 = 1'b0;
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_MIN_SPAN;
    cfg_data               = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.command      = CMD_CALIBRATE;
    sample_ch.sensor_index = '0;
    sample_ch.raw_sample   = '0;
    for (int i = 0; i < SENSOR_N; i++) begin
      cal_hi[i] = '0;
      cal_lo[i] = SAMPLE_W'(SAMPLE_MAX);
    end
    left_was_on  = 1'b0;
    right_was_on = 1'b0;
    left_edges   = '0;
    right_edges  = '0;
    span_floor   = MIN_SPAN_RST;
    marker_level = THRESHOLD_RST;
    zero = '0;
    mid  = '0;
    mid.normalized = LEVEL_W'(HALF_SCALE);

    // Directed table: typed rows hold results that follow from reset state alone.
    directed_rows.push_back('{CMD_MEASURE,    4'd0,  12'd0,    1'b1, mid});
    directed_rows.push_back('{CMD_MEASURE,    4'd13, 12'd4095, 1'b1, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd15, 12'd4095, 1'b1, zero});
    directed_rows.push_back('{CMD_CALIBRATE,  4'd15, 12'd0,    1'b1, zero});
    directed_rows.push_back('{CMD_CALIBRATE,  4'd0,  12'd0,    1'b1, zero});
    directed_rows.push_back('{CMD_CALIBRATE,  4'd0,  12'd4095, 1'b0, zero});
    directed_rows.push_back('{CMD_CALIBRATE,  4'd12, 12'd100,  1'b0, zero});
    directed_rows.push_back('{CMD_CALIBRATE,  4'd12, 12'd3000, 1'b0, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd0,  12'd0,    1'b0, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd0,  12'd4095, 1'b0, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd0,  12'd4095, 1'b0, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd0,  12'd2000, 1'b0, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd0,  12'd3000, 1'b0, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd12, 12'd4000, 1'b0, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd12, 12'd50,   1'b0, zero});
    directed_rows.push_back('{CMD_CALIBRATE,  4'd5,  12'd2000, 1'b0, zero});
    directed_rows.push_back('{CMD_CALIBRATE,  4'd5,  12'd2050, 1'b0, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd5,  12'd2020, 1'b0, zero});
    directed_rows.push_back('{CMD_CALIBRATE,  4'd6,  12'hAAA,  1'b0, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd6,  12'h555,  1'b0, zero});
    directed_rows.push_back('{CMD_RESET_MARK, 4'd0,  12'd0,    1'b1, zero});
    directed_rows.push_back('{CMD_RESET_CAL,  4'd12, 12'd4095, 1'b1, zero});
    directed_rows.push_back('{CMD_MEASURE,    4'd12, 12'd4095, 1'b0, zero});

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].sample,
                directed_rows[i].typed, directed_rows[i].want);

    // Register phases, the extremes first and the defaults last.
    set_registers(12'd0, 10'd0);
    run_phase(PHASE_RAND);
    set_registers(12'd4095, 10'd1000);
    run_phase(PHASE_RAND);
    set_registers(12'd0, 10'd1023);
    run_phase(PHASE_RAND);
    set_registers(12'd1, 10'd300);
    run_phase(PHASE_RAND);
    set_registers(SAMPLE_W'($urandom), LEVEL_W'($urandom));
    run_phase(PHASE_RAND);
    set_registers(MIN_SPAN_RST, THRESHOLD_RST);
    run_phase(PHASE_RAND);

    // Drain the outstanding results, then allow for stragglers.
    sample_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d sample beats and %0d result beats", beats_in, beats_out);
    $display("over %0d register settings after the reset defaults", settings_used);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: line_sensor_calibrate_normalize_marker_unit.f
rtl/lsn_pkg.sv
rtl/lsn_if.sv
rtl/lsn_front.sv
rtl/lsn_fifo.sv
rtl/lsn_back.sv
rtl/line_sensor_calibrate_normalize_marker_unit.sv
tb/line_sensor_calibrate_normalize_marker_unit_test.sv
